[rtl/sinc4_pkg.sv]
// ----------------------------------------------------------------------------
// sinc4_pkg: shared constants for the 4x polyphase interpolator
// Coefficient table (phase by tap), widths and the output scaling shift.
// ----------------------------------------------------------------------------
`default_nettype none

package sinc4_pkg;

	localparam int NUM_TAPS   = 4;
	localparam int NUM_PHASES = 4;
	localparam int COEF_BITS  = 16;
	localparam int COEF_SHIFT = 21 - 7;
	localparam int OUT_BITS   = 9;

	// [phase][tap], tap 0 is the newest sample
	localparam logic signed [COEF_BITS-1:0] COEF_TABLE [0:NUM_PHASES-1][0:NUM_TAPS-1] = '{
		'{16'sd0,     16'sd16284, 16'sd0,     16'sd0    },
		'{-16'sd2951, 16'sd14750, 16'sd4916,  -16'sd2108},
		'{-16'sd3477, 16'sd10430, 16'sd10430, -16'sd3477},
		'{-16'sd2108, 16'sd4916,  16'sd14750, -16'sd2951}
	};

endpackage

`default_nettype wire

[rtl/sinc4_cell.sv]
// ----------------------------------------------------------------------------
// sinc4_cell: one delay-line tap with its four phase products
// Holds one tap, passes it to the next cell and registers tap * coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc4_cell #(
	parameter int SAMPLE_BITS = 8,
	parameter int TAP_INDEX   = 0
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire logic signed [SAMPLE_BITS-1:0]        tap_in,
	output logic signed [SAMPLE_BITS-1:0]             tap_q,
	output logic [sinc4_pkg::NUM_PHASES-1:0]
		[SAMPLE_BITS+sinc4_pkg::COEF_BITS-1:0]        prod_s1
);

	localparam int PW = SAMPLE_BITS + sinc4_pkg::COEF_BITS;

	logic signed [PW-1:0] tap_ext;
	logic [sinc4_pkg::NUM_PHASES-1:0][PW-1:0] prod_c;

	// product of the incoming tap, i.e. this cell's tap after the shift
	always_comb begin
		tap_ext = PW'(tap_in);
		for (int p = 0; p < sinc4_pkg::NUM_PHASES; p++) begin
			prod_c[p] = PW'(tap_ext * PW'(sinc4_pkg::COEF_TABLE[p][TAP_INDEX]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (load) begin
			tap_q <= tap_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= prod_c;
		end
	end

endmodule

`default_nettype wire

[rtl/sinc4_phase_sum.sv]
// ----------------------------------------------------------------------------
// sinc4_phase_sum: adds one phase's tap products and scales the sum
// Floor shift by COEF_SHIFT, result wrapped to OUT_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc4_phase_sum #(
	parameter int SAMPLE_BITS = 8
) (
	input  wire logic [sinc4_pkg::NUM_TAPS-1:0]
		[SAMPLE_BITS+sinc4_pkg::COEF_BITS-1:0]    prods,
	output logic [sinc4_pkg::OUT_BITS-1:0]        result
);

	localparam int PW = SAMPLE_BITS + sinc4_pkg::COEF_BITS;
	localparam int SW = PW + $clog2(sinc4_pkg::NUM_TAPS);

	logic signed [SW-1:0] acc;

	always_comb begin
		acc = '0;
		for (int k = 0; k < sinc4_pkg::NUM_TAPS; k++) begin
			acc = acc + SW'($signed(prods[k]));
		end
		// two's complement bit select is the floor of acc / 2^shift
		result = acc[sinc4_pkg::COEF_SHIFT +: sinc4_pkg::OUT_BITS];
	end

endmodule

`default_nettype wire

[rtl/sinc_interpolator_x4_top.sv]
// ----------------------------------------------------------------------------
// sinc_interpolator_x4_top: 4x polyphase FIR interpolator
// Four-tap delay line built as a chain of cells; four phase outputs per beat.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------
//   sample   | sample_valid / sample_stall | sample [SAMPLE_BITS-1:0], signed
//   result   | result_valid / result_stall | phase_zero..phase_three [8:0], signed
//
// One beat per clock sustained while result_stall is low. A sample's result
// beat passes through the product register in the cells and then the output
// register after the per-phase adders.
// Reset clears the delay line and both valid bits; taps read zero afterwards.
// A stalled result holds; the product stage keeps taking samples until both it
// and the output register are full, then sample_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc_interpolator_x4_top #(
	parameter int SAMPLE_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [sinc4_pkg::OUT_BITS-1:0]    phase_zero,
	output logic signed [sinc4_pkg::OUT_BITS-1:0]    phase_one,
	output logic signed [sinc4_pkg::OUT_BITS-1:0]    phase_two,
	output logic signed [sinc4_pkg::OUT_BITS-1:0]    phase_three
);

	localparam int PW = SAMPLE_BITS + sinc4_pkg::COEF_BITS;

	// tap chain: taps[0] is the incoming sample, taps[k+1] is cell k's tap
	logic signed [SAMPLE_BITS-1:0] taps [0:sinc4_pkg::NUM_TAPS];

	// products by cell, then regrouped by phase for the adders
	logic [sinc4_pkg::NUM_PHASES-1:0][PW-1:0] cell_prod_s1 [0:sinc4_pkg::NUM_TAPS-1];
	logic [sinc4_pkg::NUM_TAPS-1:0][PW-1:0]   phase_prod_s1 [0:sinc4_pkg::NUM_PHASES-1];
	logic [sinc4_pkg::OUT_BITS-1:0]           phase_sum [0:sinc4_pkg::NUM_PHASES-1];
	logic [sinc4_pkg::OUT_BITS-1:0]           res_q [0:sinc4_pkg::NUM_PHASES-1];

	logic valid_s1_q;
	logic result_valid_q;
	logic accept_in;
	logic out_free;
	logic s1_adv;

	// handshake: output register frees when empty or being taken
	assign out_free     = !result_valid_q || !result_stall;
	assign s1_adv       = valid_s1_q && out_free;
	assign sample_stall = valid_s1_q && !out_free;
	assign accept_in    = sample_valid && !sample_stall;

	assign taps[0] = sample;

	// cells: each shifts its neighbor's tap in on an accepted beat
	for (genvar k = 0; k < sinc4_pkg::NUM_TAPS; k++) begin : g_cell
		sinc4_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.TAP_INDEX   (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept_in),
			.tap_in  (taps[k]),
			.tap_q   (taps[k+1]),
			.prod_s1 (cell_prod_s1[k])
		);
	end

	// per-phase adder trees
	for (genvar p = 0; p < sinc4_pkg::NUM_PHASES; p++) begin : g_phase
		for (genvar k = 0; k < sinc4_pkg::NUM_TAPS; k++) begin : g_pick
			assign phase_prod_s1[p][k] = cell_prod_s1[k][p];
		end

		sinc4_phase_sum #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_sum (
			.prods  (phase_prod_s1[p]),
			.result (phase_sum[p])
		);
	end

	// valid bits for product stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept_in) begin
				valid_s1_q <= 1'b1;
			end else if (s1_adv) begin
				valid_s1_q <= 1'b0;
			end

			if (s1_adv) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// output payload, loads only when the stage moves forward
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int p = 0; p < sinc4_pkg::NUM_PHASES; p++) begin
				res_q[p] <= phase_sum[p];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign phase_zero   = res_q[0];
	assign phase_one    = res_q[1];
	assign phase_two    = res_q[2];
	assign phase_three  = res_q[3];

	// an accepted beat always lands in the product stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> valid_s1_q)
		else $error("accepted beat did not reach product stage");

	// a product beat that may move reaches the output register
	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> result_valid)
		else $error("product beat lost before output register");

	// the delay line shifts by exactly one tap per accepted beat
	a_tap_shift: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (taps[2] == $past(taps[1]) && taps[1] == $past(sample)))
		else $error("delay line did not shift on accepted beat");

	// taps only change on an accepted beat
	a_tap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept_in |=> $stable(taps[1]) && $stable(taps[sinc4_pkg::NUM_TAPS]))
		else $error("delay line changed without an accepted beat");

	// input stalls only while both stages hold data and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1_q && result_valid && result_stall))
		else $error("sample_stall raised with room in the pipeline");

endmodule

`default_nettype wire
